[hdl/fpdc_pkg.sv]
// Shared types and constants for the fuzzy PD drive controller.
`default_nettype none

package fpdc_pkg;

  localparam int unsigned ERR_W   = 9;
  localparam int unsigned DERR_W  = 10;
  localparam int unsigned MEMB_W  = 8;
  localparam int unsigned NUM_W   = 18;
  localparam int unsigned DEN_W   = 10;
  localparam int unsigned PROD_W  = 28;
  localparam int unsigned DIV_N_W = 27;
  localparam int unsigned DIV_Q_W = 17;
  localparam int unsigned TERM_W  = 18;
  localparam int unsigned CORR_W  = 20;
  localparam int unsigned CFG_W   = 24;

  typedef enum logic [2:0] {
    REG_TARGET_TICKS    = 3'd0,
    REG_INITIAL_DRIVE   = 3'd1,
    REG_MAX_DRIVE       = 3'd2,
    REG_MEMBERSHIP_SPAN = 3'd3,
    REG_KP_GAIN_SET     = 3'd4,
    REG_KD_GAIN_SET     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [MEMB_W-1:0] neg;
    logic [MEMB_W-1:0] zero;
    logic [MEMB_W-1:0] pos;
  } memb_t;

endpackage

`default_nettype wire

[hdl/fpdc_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module fpdc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [fpdc_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [fpdc_pkg::DEN_W-1:0]   divisor,
  output logic                              done,
  output logic [fpdc_pkg::DIV_Q_W-1:0]      quotient
);

  localparam int unsigned QW = fpdc_pkg::DIV_Q_W;
  localparam int unsigned DW = fpdc_pkg::DEN_W;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;

  // Quotient fits in QW bits, so the upper dividend bits start out below the divisor.
  assign trial     = {rem, quotient[QW-1]};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CW'(QW - 1));
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= dividend[fpdc_pkg::DIV_N_W-1:QW];
        quotient <= dividend[QW-1:0];
        dvs      <= divisor;
      end else if (busy) begin
        if (!trial_sub[DW]) begin
          rem      <= trial_sub[DW-1:0];
          quotient <= {quotient[QW-2:0], 1'b1};
        end else begin
          rem      <= trial[DW-1:0];
          quotient <= {quotient[QW-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CW'(QW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/fuzzy_pd_drive_controller.sv]
// Top level: fuzzy PD drive controller with a 3x3 rule grid and shared multiply/divide.
// A request runs through fuzzification, rule evaluation, six multiply-accumulates, two
// 17-step divisions on one shared divider and a sum; a zero weight sum skips to output.
// A new request is taken only after the last result is registered; in_ready is high
// only while idle, and a result waiting on out_ready holds off the next one.
// Reset (rst, synchronous): registers take their reset values, last drive = 60,
// last error and held correction cleared, no result pending.
`default_nettype none

module fuzzy_pd_drive_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [fpdc_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 tick_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      drive_value
);

  localparam int unsigned MW = fpdc_pkg::MEMB_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FUZZ, S_RULE, S_MAC, S_MULP, S_DIVP, S_MULD, S_DIVD, S_SUM, S_OUT
  } state_t;

  state_t state;

  logic [7:0]  target_ticks, max_drive, membership_span;
  logic [23:0] kp_gain_set, kd_gain_set;

  logic signed [fpdc_pkg::ERR_W-1:0]  last_error;
  logic [7:0]                         last_drive;
  logic signed [fpdc_pkg::CORR_W-1:0] held_correction;

  logic signed [fpdc_pkg::ERR_W-1:0]  err;
  logic signed [fpdc_pkg::DERR_W-1:0] derr;
  fpdc_pkg::memb_t                    e_m, d_m;
  logic [MW-1:0]                      w [6];
  logic [fpdc_pkg::DEN_W-1:0]         pden, dden;
  logic [fpdc_pkg::NUM_W-1:0]         pnum, dnum;
  logic [2:0]                         mac_k;
  logic signed [fpdc_pkg::PROD_W-1:0] prod;
  logic signed [fpdc_pkg::TERM_W-1:0] term_p, term_d;
  logic                               div_start;

  // Combinational helpers
  logic signed [fpdc_pkg::ERR_W-1:0]  err_next;
  logic signed [fpdc_pkg::DERR_W-1:0] derr_next;
  fpdc_pkg::memb_t                    e_next, d_next;
  logic [MW-1:0]                      e_a [3];
  logic [MW-1:0]                      d_a [3];
  logic [MW-1:0]                      g [3][3];
  logic [MW-1:0]                      w_next [6];
  logic [fpdc_pkg::DEN_W-1:0]         pden_next, dden_next;
  logic [fpdc_pkg::NUM_W-1:0]         mul_a;
  logic signed [fpdc_pkg::DERR_W-1:0] mul_b;
  logic signed [fpdc_pkg::PROD_W:0]   mul_full;
  logic [7:0]                         mac_gain;
  logic [fpdc_pkg::PROD_W-1:0]        prod_mag;
  logic                               div_done;
  logic [fpdc_pkg::DIV_Q_W-1:0]       div_q;
  logic signed [fpdc_pkg::TERM_W-1:0] term_next;
  logic signed [fpdc_pkg::CORR_W:0]   drive_sum;
  logic [7:0]                         drive_clamped;

  function automatic fpdc_pkg::memb_t fuzz(input logic signed [9:0] v, input logic [7:0] span);
    logic signed [10:0] vs, sp, negv, diff, summ;
    fpdc_pkg::memb_t    m;
    vs   = {v[9], v};
    sp   = {3'b000, span};
    negv = -vs;
    diff = sp - vs;
    summ = sp + vs;
    m    = '0;
    if (!v[9] && v != 10'sd0) begin
      m.pos  = (vs < sp) ? vs[7:0] : span;
      m.zero = diff[10] ? 8'd0 : diff[7:0];
    end else if (v[9]) begin
      m.neg  = (negv < sp) ? negv[7:0] : span;
      m.zero = summ[10] ? 8'd0 : summ[7:0];
    end
    return m;
  endfunction

  function automatic logic [7:0] mn8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] mx8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  assign err_next  = $signed({1'b0, target_ticks}) - $signed({1'b0, tick_count});
  assign derr_next = {err_next[8], err_next} - {last_error[8], last_error};

  assign e_next = fuzz({err[8], err}, membership_span);
  assign d_next = fuzz(derr, membership_span);

  assign e_a = '{e_m.neg, e_m.zero, e_m.pos};
  assign d_a = '{d_m.neg, d_m.zero, d_m.pos};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        g[i][j] = mn8(e_a[i], d_a[j]);
      end
    end
    w_next[0] = g[1][1];
    w_next[1] = mx8(mx8(mx8(g[1][0], g[0][1]), mx8(g[2][1], g[1][2])),
                    mx8(g[0][0], g[2][2]));
    w_next[2] = mx8(g[0][2], g[2][0]);
    w_next[3] = mx8(mx8(g[0][2], g[2][0]), g[1][1]);
    w_next[4] = mx8(mx8(g[0][0], g[0][1]), mx8(g[2][1], g[2][2]));
    w_next[5] = mx8(g[1][0], g[1][2]);
  end

  assign pden_next = {2'b00, w_next[0]} + {2'b00, w_next[1]} + {2'b00, w_next[2]};
  assign dden_next = {2'b00, w_next[3]} + {2'b00, w_next[4]} + {2'b00, w_next[5]};

  always_comb begin
    unique case (mac_k)
      3'd0:    mac_gain = kp_gain_set[7:0];
      3'd1:    mac_gain = kp_gain_set[15:8];
      3'd2:    mac_gain = kp_gain_set[23:16];
      3'd3:    mac_gain = kd_gain_set[7:0];
      3'd4:    mac_gain = kd_gain_set[15:8];
      3'd5:    mac_gain = kd_gain_set[23:16];
      default: mac_gain = 8'd0;
    endcase
  end

  // Shared multiplier
  always_comb begin
    unique case (state)
      S_MAC: begin
        mul_a = {10'd0, mac_gain};
        mul_b = {2'b00, (mac_k < 3'd6) ? w[mac_k] : 8'd0};
      end
      S_MULP: begin
        mul_a = pnum;
        mul_b = {err[8], err};
      end
      S_MULD: begin
        mul_a = dnum;
        mul_b = derr;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = $signed({1'b0, mul_a}) * mul_b;

  assign prod_mag  = prod[fpdc_pkg::PROD_W-1] ? (-prod) : prod;
  assign term_next = prod[fpdc_pkg::PROD_W-1] ? -$signed({1'b0, div_q})
                                              : $signed({1'b0, div_q});

  fpdc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[fpdc_pkg::DIV_N_W-1:0]),
    .divisor  ((state == S_DIVP) ? pden : dden),
    .done     (div_done),
    .quotient (div_q)
  );

  assign drive_sum = $signed({13'd0, last_drive}) + {held_correction[19], held_correction};

  always_comb begin
    if (drive_sum[fpdc_pkg::CORR_W]) begin
      drive_clamped = 8'd0;
    end else if (drive_sum > $signed({13'd0, max_drive})) begin
      drive_clamped = max_drive;
    end else begin
      drive_clamped = drive_sum[7:0];
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      div_start       <= 1'b0;
      target_ticks    <= 8'd60;
      max_drive       <= 8'd127;
      membership_span <= 8'd10;
      kp_gain_set     <= 24'd197121;
      kd_gain_set     <= 24'd591363;
      last_error      <= '0;
      last_drive      <= 8'd60;
      held_correction <= '0;
      mac_k           <= '0;
    end else begin
      div_start <= (state == S_MULP) || (state == S_MULD);
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err        <= err_next;
            derr       <= derr_next;
            last_error <= err_next;
            state      <= S_FUZZ;
          end
        end
        S_FUZZ: begin
          e_m   <= e_next;
          d_m   <= d_next;
          state <= S_RULE;
        end
        S_RULE: begin
          w     <= w_next;
          pden  <= pden_next;
          dden  <= dden_next;
          pnum  <= '0;
          dnum  <= '0;
          mac_k <= '0;
          if (pden_next == '0 || dden_next == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (mac_k < 3'd3) begin
            pnum <= pnum + mul_full[fpdc_pkg::NUM_W-1:0];
          end else begin
            dnum <= dnum + mul_full[fpdc_pkg::NUM_W-1:0];
          end
          mac_k <= mac_k + 3'd1;
          if (mac_k == 3'd5) begin
            state <= S_MULP;
          end
        end
        S_MULP: begin
          prod  <= mul_full[fpdc_pkg::PROD_W-1:0];
          state <= S_DIVP;
        end
        S_DIVP: begin
          if (div_done) begin
            term_p <= term_next;
            state  <= S_MULD;
          end
        end
        S_MULD: begin
          prod  <= mul_full[fpdc_pkg::PROD_W-1:0];
          state <= S_DIVD;
        end
        S_DIVD: begin
          if (div_done) begin
            term_d <= term_next;
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          held_correction <= {{2{term_p[17]}}, term_p} + {{2{term_d[17]}}, term_d};
          state           <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            drive_value <= drive_clamped;
            last_drive  <= drive_clamped;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          fpdc_pkg::REG_TARGET_TICKS:    target_ticks <= cfg_data[7:0];
          fpdc_pkg::REG_INITIAL_DRIVE:   last_drive <= cfg_data[7:0];
          fpdc_pkg::REG_MAX_DRIVE:       max_drive <= cfg_data[7:0];
          fpdc_pkg::REG_MEMBERSHIP_SPAN: membership_span <= cfg_data[7:0];
          fpdc_pkg::REG_KP_GAIN_SET:     kp_gain_set <= cfg_data;
          fpdc_pkg::REG_KD_GAIN_SET:     kd_gain_set <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVP || state == S_DIVD))
    else $error("divider finished outside a divide state");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVP || state == S_DIVD) |-> (pden != '0 && dden != '0))
    else $error("division started with a zero weight sum");

  a_mac_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && mac_k == 3'd5) |=> (state == S_MULP))
    else $error("multiply-accumulate did not end after six steps");

endmodule

`default_nettype wire

[dv/fuzzy_pd_drive_controller_tb.sv]
// Self-checking testbench for fuzzy_pd_drive_controller with a built-in drive predictor.
`timescale 1ns / 1ps

module fuzzy_pd_drive_controller_tb;

  localparam logic [2:0] SPARE_IDX_LO = 3'd6;
  localparam logic [2:0] SPARE_IDX_HI = 3'd7;
  localparam int MB_NEG = 0;
  localparam int MB_ZRO = 1;
  localparam int MB_POS = 2;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [2:0]                 cfg_index;
  logic [fpdc_pkg::CFG_W-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 tick_count;
  logic                       out_valid;
  logic                       out_ready;
  logic [7:0]                 drive_value;

  fuzzy_pd_drive_controller dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .tick_count(tick_count),
    .out_valid(out_valid), .out_ready(out_ready), .drive_value(drive_value)
  );

  always #4 clk = ~clk;

  // controller model state
  int          tgt_ticks, init_drive, max_drv, span;
  logic [23:0] kp_set, kd_set;
  int          last_err, last_drv, held_corr;

  logic [7:0]  drive_q[$];
  logic [7:0]  want_drive;
  int          fail_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_len = 0;

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] clamp_tick(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic int memb(input int v, input int sp, input int k);
    if (k == MB_NEG) return (v < 0) ? imin(-v, sp) : 0;
    if (k == MB_POS) return (v > 0) ? imin(v, sp) : 0;
    if (v > 0) return imax(sp - v, 0);
    if (v < 0) return imax(sp + v, 0);
    return 0;
  endfunction

  function automatic void reset_model();
    tgt_ticks  = 60;
    init_drive = 60;
    max_drv    = 127;
    span       = 10;
    kp_set     = 24'h030201;
    kd_set     = 24'h090603;
    last_err   = 0;
    last_drv   = 60;
    held_corr  = 0;
  endfunction

  function automatic void apply_cfg(input logic [2:0] idx,
                                    input logic [fpdc_pkg::CFG_W-1:0] val);
    case (idx)
      fpdc_pkg::REG_TARGET_TICKS:    tgt_ticks = int'(val[7:0]);
      fpdc_pkg::REG_INITIAL_DRIVE: begin
        init_drive = int'(val[7:0]);
        last_drv   = init_drive;
      end
      fpdc_pkg::REG_MAX_DRIVE:       max_drv = int'(val[7:0]);
      fpdc_pkg::REG_MEMBERSHIP_SPAN: span = int'(val[7:0]);
      fpdc_pkg::REG_KP_GAIN_SET:     kp_set = val[23:0];
      fpdc_pkg::REG_KD_GAIN_SET:     kd_set = val[23:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] step_drive(input logic [7:0] ticks);
    int err, derr, ps, pm, pl, ds, dm, dl, pnum, pden, dnum, dden, sum;
    int g[3][3];
    err  = tgt_ticks - int'(ticks);
    derr = err - last_err;
    last_err = err;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        g[i][j] = imin(memb(err, span, i), memb(derr, span, j));
    ps = g[MB_ZRO][MB_ZRO];
    pm = imax(imax(imax(g[MB_ZRO][MB_NEG], g[MB_NEG][MB_ZRO]),
                   imax(g[MB_POS][MB_ZRO], g[MB_ZRO][MB_POS])),
              imax(g[MB_NEG][MB_NEG], g[MB_POS][MB_POS]));
    pl = imax(g[MB_NEG][MB_POS], g[MB_POS][MB_NEG]);
    ds = imax(imax(g[MB_NEG][MB_POS], g[MB_POS][MB_NEG]), g[MB_ZRO][MB_ZRO]);
    dm = imax(imax(g[MB_NEG][MB_NEG], g[MB_NEG][MB_ZRO]),
              imax(g[MB_POS][MB_ZRO], g[MB_POS][MB_POS]));
    dl = imax(g[MB_ZRO][MB_NEG], g[MB_ZRO][MB_POS]);
    pnum = ps * int'(kp_set[7:0]) + pm * int'(kp_set[15:8]) + pl * int'(kp_set[23:16]);
    dnum = ds * int'(kd_set[7:0]) + dm * int'(kd_set[15:8]) + dl * int'(kd_set[23:16]);
    pden = ps + pm + pl;
    dden = ds + dm + dl;
    // zero weight sum: correction held
    if (pden != 0 && dden != 0)
      held_corr = (err * pnum) / pden + (derr * dnum) / dden;
    sum = last_drv + held_corr;
    if (sum < 0) sum = 0;
    if (sum > max_drv) sum = max_drv;
    last_drv = sum;
    return sum[7:0];
  endfunction

  // one request; valid stays up inside a burst
  task automatic offer_ticks(input logic [7:0] t);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    tick_count <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_q.push_back(step_drive(t));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 60);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [fpdc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, val);
  endtask

  function automatic logic [7:0] near_target();
    return clamp_tick(tgt_ticks + $urandom_range(0, 2 * span + 8) - span - 4);
  endfunction

  function automatic logic [23:0] pick_gains();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2, 3, 4: return 24'($urandom);
      default: return {4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom)};
    endcase
  endfunction

  task automatic test_reset_defaults();
    offer_ticks(8'd60);
    offer_ticks(8'd50);
    offer_ticks(8'd70);
    offer_ticks(8'd0);
    offer_ticks(8'd255);
    offer_ticks(8'd60);
    settle();
  endtask

  task automatic test_register_extremes();
    cfg_write(fpdc_pkg::REG_TARGET_TICKS, 24'd255);
    cfg_write(fpdc_pkg::REG_MEMBERSHIP_SPAN, 24'd255);
    cfg_write(fpdc_pkg::REG_KP_GAIN_SET, 24'hFFFFFF);
    cfg_write(fpdc_pkg::REG_KD_GAIN_SET, 24'hFFFFFF);
    cfg_write(fpdc_pkg::REG_MAX_DRIVE, 24'd255);
    cfg_write(fpdc_pkg::REG_INITIAL_DRIVE, 24'd0);
    offer_ticks(8'd0);
    offer_ticks(8'd255);
    offer_ticks(8'd128);
    offer_ticks(8'd0);
    settle();
    cfg_write(fpdc_pkg::REG_TARGET_TICKS, 24'd0);
    cfg_write(fpdc_pkg::REG_MEMBERSHIP_SPAN, 24'd1);
    cfg_write(fpdc_pkg::REG_KP_GAIN_SET, 24'h000000);
    cfg_write(fpdc_pkg::REG_KD_GAIN_SET, 24'h000000);
    cfg_write(fpdc_pkg::REG_INITIAL_DRIVE, 24'd255);
    offer_ticks(8'd255);
    offer_ticks(8'd0);
    offer_ticks(8'd1);
    settle();
    // zero span: every weight sum is zero
    cfg_write(fpdc_pkg::REG_KP_GAIN_SET, 24'h0A0B0C);
    cfg_write(fpdc_pkg::REG_MEMBERSHIP_SPAN, 24'd0);
    offer_ticks(8'd10);
    offer_ticks(8'd200);
    settle();
    cfg_write(fpdc_pkg::REG_MEMBERSHIP_SPAN, 24'd20);
    cfg_write(fpdc_pkg::REG_MAX_DRIVE, 24'd0);
    offer_ticks(8'd5);
    offer_ticks(8'd250);
    settle();
    // writes past the register list are dropped
    cfg_write(SPARE_IDX_LO, 24'hFFFFFF);
    cfg_write(SPARE_IDX_HI, 24'hFFFFFF);
    cfg_write(fpdc_pkg::REG_MAX_DRIVE, 24'd200);
    offer_ticks(8'd3);
    offer_ticks(8'd9);
    settle();
  endtask

  task automatic test_initial_drive_load();
    cfg_write(fpdc_pkg::REG_TARGET_TICKS, 24'd100);
    cfg_write(fpdc_pkg::REG_INITIAL_DRIVE, 24'd200);
    offer_ticks(8'd95);
    offer_ticks(8'd104);
    settle();
    cfg_write(fpdc_pkg::REG_INITIAL_DRIVE, 24'd0);
    offer_ticks(8'd90);
    offer_ticks(8'd100);
    settle();
  endtask

  task automatic test_output_backpressure();
    gaps_on  = 1'b0;
    hold_len = 400;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) offer_ticks(near_target());
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 12; i++) offer_ticks(near_target());
    settle();
    for (int i = 0; i < 12; i++) offer_ticks(near_target());
    settle();
  endtask

  task automatic randomize_setup();
    int r;
    r = $urandom_range(0, 7);
    cfg_write(fpdc_pkg::REG_TARGET_TICKS,
              (r == 0) ? 24'd0 : (r == 1) ? 24'd255 : 24'($urandom_range(0, 255)));
    r = $urandom_range(0, 19);
    cfg_write(fpdc_pkg::REG_MEMBERSHIP_SPAN,
              (r == 0) ? 24'd0 : (r < 3) ? 24'd255 : 24'($urandom_range(1, 40)));
    r = $urandom_range(0, 9);
    cfg_write(fpdc_pkg::REG_MAX_DRIVE,
              (r == 0) ? 24'd0 : (r == 1) ? 24'd255 : 24'($urandom_range(30, 255)));
    cfg_write(fpdc_pkg::REG_KP_GAIN_SET, pick_gains());
    cfg_write(fpdc_pkg::REG_KD_GAIN_SET, pick_gains());
    if ($urandom_range(0, 1)) cfg_write(fpdc_pkg::REG_INITIAL_DRIVE, 24'($urandom));
    if ($urandom_range(0, 7) == 0)
      cfg_write(SPARE_IDX_LO + 3'($urandom_range(0, 1)), 24'($urandom));
  endtask

  task automatic test_random_tracking();
    int r;
    logic [7:0] t, prev_t;
    prev_t = 8'd0;
    for (int phase = 0; phase < 20; phase++) begin
      randomize_setup();
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 80; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) t = clamp_tick(last_drv + $urandom_range(0, 10) - 5);
        else if (r < 75) t = near_target();
        else if (r < 85) t = prev_t;
        else t = 8'($urandom);
        offer_ticks(t);
        prev_t = t;
      end
      settle();
    end
    gaps_on = 1'b1;
  endtask

  // result sink: stall pattern plus on-demand long hold-off
  initial begin
    rx_mode_t rx_mode;
    int mode_left, stall_left;
    out_ready  = 1'b0;
    rx_mode    = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(30, 200);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              out_ready <= 1'b0;
              stall_left--;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 60);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected drive_value, expected none, actual %0d", $time, drive_value);
        fail_count++;
      end else begin
        want_drive = drive_q.pop_front();
        if (drive_value !== want_drive) begin
          $display("%0t: drive_value mismatch, expected %0d, actual %0d",
                   $time, want_drive, drive_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = 3'd0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    tick_count = 8'd0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_initial_drive_load();
    test_output_backpressure();
    test_sender_pause();
    test_random_tracking();

    settle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && drive_q.size() == 0)
      $display("fuzzy_pd_drive_controller test passed");
    else
      $display("fuzzy_pd_drive_controller test failed");
    $finish;
  end

  initial begin
    #16000000;
    $display("fuzzy_pd_drive_controller test failed");
    $finish;
  end

endmodule
